// File: hw/rtl/mhf_pkg.sv
// ----------------------------------------------------------------------------
// mhf_pkg
// Shared constants for the multicast hash filter with reference counts.
// ----------------------------------------------------------------------------
`default_nettype none

package mhf_pkg;

    localparam int unsigned REF_COUNT_BITS_DEF = 8;
    localparam int unsigned NUM_BUCKETS        = 64;
    localparam int unsigned IDX_W              = $clog2(NUM_BUCKETS);
    localparam int unsigned MAC_W              = 48;
    localparam int unsigned REF_OUT_W          = 8;
    localparam int unsigned GROUP_BIT          = 40;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

endpackage

`default_nettype wire

// File: hw/rtl/mhf_if.sv
// ----------------------------------------------------------------------------
// mhf_if
// Request and response channels, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhf_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [47:0] mac_addr;

    modport source (output valid, output req_type, output mac_addr, input ready);
    modport sink   (input valid, input req_type, input mac_addr, output ready);
endinterface

interface mhf_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [5:0]  hash_index;
    logic [7:0]  ref_now;
    logic        filter_changed;
    logic [63:0] filter_bits;

    modport source (output valid, output status, output hash_index, output ref_now,
                    output filter_changed, output filter_bits, input ready);
    modport sink   (input valid, input status, input hash_index, input ref_now,
                    input filter_changed, input filter_bits, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/multicast_hash_filter_refcount_core.sv
// ----------------------------------------------------------------------------
// multicast_hash_filter_refcount_core
// Multicast hash filter with per-bucket reference counts.
// A request passes the stage A, stage B and response registers in turn.
// Throughput: one request per cycle without response backpressure; the count
// read-modify-write is closed by a bypass on the count bank read port.
// Reset: counts read as zero (per-bucket valid bits) and the filter is clear;
// requests are taken in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module multicast_hash_filter_refcount_core #(
    parameter int unsigned REF_COUNT_BITS = mhf_pkg::REF_COUNT_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mhf_req_if.sink     req,
    mhf_rsp_if.source   rsp
);
    import mhf_pkg::*;

    localparam logic [REF_COUNT_BITS-1:0] REF_MAX = {REF_COUNT_BITS{1'b1}};

    // stage A: request register
    logic             a_valid_reg;
    logic             a_op_reg;
    logic [MAC_W-1:0] a_mac_reg;
    logic [IDX_W-1:0] a_idx;
    logic             a_group;

    // stage B: count read done, update
    logic             b_valid_reg;
    logic             b_op_reg;
    logic             b_rej_reg;
    logic [IDX_W-1:0] b_idx_reg;

    logic [NUM_BUCKETS-1:0]    filter_reg;
    logic [NUM_BUCKETS-1:0]    filter_next;
    logic [REF_COUNT_BITS-1:0] cnt;
    logic [REF_COUNT_BITS-1:0] cnt_next;

    // response register
    logic                   out_valid_reg;
    logic                   out_status_reg;
    logic [IDX_W-1:0]       out_idx_reg;
    logic [REF_OUT_W-1:0]   out_ref_reg;
    logic                   out_changed_reg;
    logic [NUM_BUCKETS-1:0] out_filter_reg;

    logic out_free;
    logic b_adv;
    logic b_free;
    logic a_adv;
    logic in_xfer;
    logic wr_en;

    assign out_free = !out_valid_reg || rsp.ready;
    assign b_adv    = b_valid_reg && out_free;
    assign b_free   = !b_valid_reg || b_adv;
    assign a_adv    = a_valid_reg && b_free;
    assign req.ready = !a_valid_reg || a_adv;
    assign in_xfer  = req.valid && req.ready;
    assign wr_en    = b_adv && !b_rej_reg;

    mhf_hash u_hash (
        .mac   (a_mac_reg),
        .idx   (a_idx),
        .group (a_group)
    );

    mhf_ref_bank #(
        .COUNT_BITS (REF_COUNT_BITS)
    ) u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (a_adv),
        .rd_addr (a_idx),
        .rd_data (cnt),
        .wr_en   (wr_en),
        .wr_addr (b_idx_reg),
        .wr_data (cnt_next)
    );

    always_comb
    begin
        filter_next = filter_reg;
        if (b_op_reg == REQ_ADD)
        begin
            cnt_next = (cnt == REF_MAX) ? cnt : cnt + REF_COUNT_BITS'(1);
            filter_next[b_idx_reg] = 1'b1;
        end
        else
        begin
            cnt_next = (cnt == '0) ? cnt : cnt - REF_COUNT_BITS'(1);
            if (cnt_next == '0)
            begin
                filter_next[b_idx_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            filter_reg    <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                a_valid_reg <= req.valid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= b_valid_reg;
            end
            if (wr_en)
            begin
                filter_reg <= filter_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_op_reg  <= req.req_type;
            a_mac_reg <= req.mac_addr;
        end
        if (a_adv)
        begin
            b_op_reg  <= a_op_reg;
            b_rej_reg <= !a_group;
            b_idx_reg <= a_idx;
        end
        if (b_adv)
        begin
            if (b_rej_reg)
            begin
                out_status_reg  <= STATUS_REJECT;
                out_idx_reg     <= '0;
                out_ref_reg     <= '0;
                out_changed_reg <= 1'b0;
                out_filter_reg  <= filter_reg;
            end
            else
            begin
                out_status_reg  <= STATUS_DONE;
                out_idx_reg     <= b_idx_reg;
                out_ref_reg     <= REF_OUT_W'(cnt_next);
                out_changed_reg <= (filter_next != filter_reg);
                out_filter_reg  <= filter_next;
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.hash_index     = out_idx_reg;
    assign rsp.ref_now        = out_ref_reg;
    assign rsp.filter_changed = out_changed_reg;
    assign rsp.filter_bits    = out_filter_reg;

    a_add_sets_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && !b_rej_reg && b_op_reg == REQ_ADD) |=> filter_reg[$past(b_idx_reg)])
        else $error("add did not set filter bit");

    a_reject_keeps_filter: assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && b_rej_reg) |=> $stable(filter_reg))
        else $error("rejected request changed filter");

    a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STATUS_REJECT) |->
        (rsp.hash_index == '0 && rsp.ref_now == '0 && !rsp.filter_changed))
        else $error("rejected response carries bucket data");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (a_valid_reg && b_valid_reg && out_valid_reg && !rsp.ready))
        else $error("request stalled without downstream backpressure");

endmodule

`default_nettype wire

// File: hw/rtl/mhf_hash.sv
// ----------------------------------------------------------------------------
// mhf_hash
// Reflected CRC-32 over the six address bytes; the low six CRC bits, in reversed order, give the 6-bit bucket.
// ----------------------------------------------------------------------------
`default_nettype none

module mhf_hash (
    input  wire logic [mhf_pkg::MAC_W-1:0] mac,
    output logic [mhf_pkg::IDX_W-1:0]      idx,
    output logic                           group
);
    import mhf_pkg::*;

    // unrolls to a flat XOR network
    function automatic logic [31:0] crc_of_mac(input logic [MAC_W-1:0] m);
        logic [31:0] crc;
        logic        fb;
        crc = CRC_INIT;
        for (int b = 0; b < 6; b++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                fb  = crc[0] ^ m[40 - 8 * b + k];
                crc = (crc >> 1) ^ (fb ? CRC_POLY : 32'h0);
            end
        end
        return crc;
    endfunction

    logic [31:0] crc;

    always_comb
    begin
        crc = crc_of_mac(mac);
        for (int i = 0; i < IDX_W; i++)
        begin
            idx[IDX_W-1-i] = crc[i];
        end
        group = mac[GROUP_BIT];
    end

endmodule

`default_nettype wire

// File: hw/rtl/mhf_ref_bank.sv
// ----------------------------------------------------------------------------
// mhf_ref_bank
// Per-bucket reference counts: one write port, one registered read port with
// write-to-read bypass; per-entry valid bits give zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mhf_ref_bank #(
    parameter int unsigned COUNT_BITS = mhf_pkg::REF_COUNT_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [mhf_pkg::IDX_W-1:0] rd_addr,
    output logic [COUNT_BITS-1:0]          rd_data,
    input  wire logic                      wr_en,
    input  wire logic [mhf_pkg::IDX_W-1:0] wr_addr,
    input  wire logic [COUNT_BITS-1:0]     wr_data
);
    import mhf_pkg::*;

    logic [COUNT_BITS-1:0]  mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] valid_reg;
    logic [COUNT_BITS-1:0]  rd_data_reg;
    logic                   rd_ok_reg;
    logic                   bypass;

    assign bypass = wr_en && rd_en && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= bypass ? wr_data : mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= bypass || valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_ok_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// File: verif/multicast_hash_filter_refcount_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multicast_hash_filter_refcount_core_tb
// Self-checking bench for the refcounted multicast hash filter. A driver
// sends add/remove requests from a queue in random bursts. Each request
// transfer is run through a local CRC-32 bucket and refcount predictor. A
// monitor with its own stall pattern compares every response field with the
// oldest prediction. The stimulus covers directed corner cases, a
// saturate-and-drain run on one bucket, and random traffic mostly over a small
// address pool.
// ----------------------------------------------------------------------------
module multicast_hash_filter_refcount_core_tb;

    import mhf_pkg::*;

    localparam int unsigned REF_BITS   = REF_COUNT_BITS_DEF;
    localparam int          RAND_ITEMS = 316;
    localparam int          SAT_RUN    = (1 << REF_BITS) + 2;
    localparam int          LONG_HOLD  = 80;
    localparam int          HOLD_AT    = 760;

    typedef struct packed {
        logic        drain_first;
        logic        req_type;
        logic [47:0] mac;
    } mac_req_t;

    typedef struct packed {
        logic                 status;
        logic [IDX_W-1:0]     hash_index;
        logic [REF_OUT_W-1:0] ref_now;
        logic                 filter_changed;
        logic [63:0]          filter_bits;
    } filter_result_t;

    logic clk = 1'b0;
    logic rst_n;

    mhf_req_if req_bus();
    mhf_rsp_if rsp_bus();

    multicast_hash_filter_refcount_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #1 clk = ~clk;

    logic [REF_BITS-1:0] bucket_count [NUM_BUCKETS];
    logic [63:0]         filter_shadow;

    mac_req_t       queued_reqs[$];
    filter_result_t expected_updates[$];

    int error_count;
    int req_transfers;
    int rsp_transfers;
    int n_add, n_remove, n_reject, n_saturated, n_remove_at_zero, n_filter_flips;
    int peak_count;

    function automatic logic [31:0] mac_crc32(input logic [47:0] mac);
        logic [31:0] crc;
        logic [7:0]  octet;
        crc = CRC_INIT;
        for (int b = 0; b < 6; b++)
        begin
            octet = mac[47 - 8 * b -: 8];
            for (int k = 0; k < 8; k++)
            begin
                if (crc[0] ^ octet[k])
                    crc = (crc >> 1) ^ CRC_POLY;
                else
                    crc = crc >> 1;
            end
        end
        return crc;
    endfunction

    function filter_result_t predict_filter_update(input logic op, input logic [47:0] mac);
        filter_result_t      res;
        logic [31:0]         crc;
        logic [IDX_W-1:0]    idx;
        logic [REF_BITS-1:0] cnt;
        logic [63:0]         prior;
        res = '0;
        if (mac[GROUP_BIT] == 1'b0)
        begin
            n_reject++;
            res.status      = STATUS_REJECT;
            res.filter_bits = filter_shadow;
            return res;
        end
        crc = mac_crc32(mac);
        for (int i = 0; i < IDX_W; i++)
            idx[IDX_W - 1 - i] = crc[i];
        cnt   = bucket_count[idx];
        prior = filter_shadow;
        if (op == REQ_ADD)
        begin
            n_add++;
            if (cnt != {REF_BITS{1'b1}})
                cnt++;
            else
                n_saturated++;
            filter_shadow[idx] = 1'b1;
        end
        else
        begin
            n_remove++;
            if (cnt != '0)
                cnt--;
            else
                n_remove_at_zero++;
            if (cnt == '0)
                filter_shadow[idx] = 1'b0;
        end
        bucket_count[idx] = cnt;
        if (int'(cnt) > peak_count)
            peak_count = int'(cnt);
        res.status         = STATUS_DONE;
        res.hash_index     = idx;
        res.ref_now        = REF_OUT_W'(cnt);
        res.filter_changed = (prior != filter_shadow);
        res.filter_bits    = filter_shadow;
        if (res.filter_changed)
            n_filter_flips++;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic queue_req(input logic op, input logic [47:0] mac, input logic drain);
        mac_req_t r;
        r.drain_first = drain;
        r.req_type    = op;
        r.mac         = mac;
        queued_reqs.push_back(r);
    endtask

    function automatic logic [47:0] random_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // request driver
    mac_req_t next_req;
    int       burst_left;
    int       gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid    <= 1'b0;
            req_bus.req_type <= REQ_ADD;
            req_bus.mac_addr <= '0;
            burst_left = 4;
            gap_left   = 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                expected_updates.push_back(
                    predict_filter_update(req_bus.req_type, req_bus.mac_addr));
                req_transfers++;
            end
            if (!req_bus.valid || req_bus.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_bus.valid <= 1'b0;
                end
                else if (queued_reqs.size() != 0 &&
                         !(queued_reqs[0].drain_first && expected_updates.size() != 0))
                begin
                    next_req = queued_reqs.pop_front();
                    req_bus.valid    <= 1'b1;
                    req_bus.req_type <= next_req.req_type;
                    req_bus.mac_addr <= next_req.mac;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    // response monitor and ready pattern
    filter_result_t want;
    int             hold_left;
    bit             long_hold_done;
    int             window_left;
    int             stall_mode;
    int             rx_cycle;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            hold_left      = 0;
            long_hold_done = 1'b0;
            window_left    = 0;
            stall_mode     = 0;
            rx_cycle       = 0;
        end
        else
        begin
            rx_cycle++;
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                rsp_transfers++;
                if (expected_updates.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: unexpected response, expected none, actual index %0d",
                             $time, rsp_bus.hash_index);
                end
                else
                begin
                    want = expected_updates.pop_front();
                    check_field("status", want.status, rsp_bus.status);
                    check_field("hash_index", want.hash_index, rsp_bus.hash_index);
                    check_field("ref_now", want.ref_now, rsp_bus.ref_now);
                    check_field("filter_changed", want.filter_changed,
                                rsp_bus.filter_changed);
                    check_field("filter_bits", want.filter_bits, rsp_bus.filter_bits);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (!long_hold_done && req_transfers >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                if (window_left == 0)
                begin
                    stall_mode  = $urandom_range(0, 3);
                    window_left = 64;
                end
                window_left--;
                case (stall_mode)
                    0:       rsp_bus.ready <= 1'b1;
                    1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_bus.ready <= (rx_cycle[2:0] != 3'd0);
                endcase
            end
        end
    end

    // stimulus and end of run
    logic [47:0] addr_pool [12];
    logic [47:0] sat_mac;
    logic [47:0] mac;
    logic        op;
    int          add_pct;

    initial
    begin
        rst_n            = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.req_type = REQ_ADD;
        req_bus.mac_addr = '0;
        rsp_bus.ready    = 1'b0;
        error_count      = 0;
        req_transfers    = 0;
        rsp_transfers    = 0;
        n_add = 0; n_remove = 0; n_reject = 0;
        n_saturated = 0; n_remove_at_zero = 0; n_filter_flips = 0;
        peak_count       = 0;
        filter_shadow    = '0;
        for (int i = 0; i < NUM_BUCKETS; i++)
            bucket_count[i] = '0;

        // directed corners
        queue_req(REQ_ADD,    48'h0000_0000_0000, 1'b0);
        queue_req(REQ_ADD,    48'hFFFF_FFFF_FFFF, 1'b0);
        queue_req(REQ_ADD,    48'hFFFF_FFFF_FFFF, 1'b0);
        queue_req(REQ_REMOVE, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_req(REQ_REMOVE, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_req(REQ_REMOVE, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_req(REQ_REMOVE, 48'h0000_0000_0000, 1'b0);
        queue_req(REQ_ADD,    48'hFEFF_FFFF_FFFF, 1'b0);
        queue_req(REQ_ADD,    48'h0100_0000_0000, 1'b0);
        queue_req(REQ_ADD,    48'h0180_C200_0000, 1'b0);
        queue_req(REQ_ADD,    48'h0100_5E00_0001, 1'b0);
        queue_req(REQ_ADD,    48'h3333_0000_0001, 1'b0);
        queue_req(REQ_REMOVE, 48'h0180_C200_0000, 1'b0);
        queue_req(REQ_REMOVE, 48'h0100_0000_0000, 1'b0);
        queue_req(REQ_REMOVE, 48'h3333_0000_0001, 1'b0);
        queue_req(REQ_REMOVE, 48'h0100_5E00_0001, 1'b0);
        queue_req(REQ_ADD,    48'h0000_0000_0001, 1'b0);
        queue_req(REQ_REMOVE, 48'hFFFF_FFFF_FFFF, 1'b0);

        // one bucket pushed past saturation, then drained past zero
        sat_mac            = random_mac();
        sat_mac[GROUP_BIT] = 1'b1;
        for (int i = 0; i < SAT_RUN; i++)
            queue_req(REQ_ADD, sat_mac, i == 0);
        for (int i = 0; i < SAT_RUN; i++)
            queue_req(REQ_REMOVE, sat_mac, 1'b0);

        // random traffic, mostly on a small group-address pool
        for (int i = 0; i < 12; i++)
        begin
            addr_pool[i]            = random_mac();
            addr_pool[i][GROUP_BIT] = 1'b1;
        end
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            add_pct = (i < RAND_ITEMS / 2) ? 65 : 35;
            op      = ($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_REMOVE;
            if ($urandom_range(0, 99) < 60)
                mac = addr_pool[$urandom_range(0, 11)];
            else
                mac = random_mac();
            queue_req(op, mac, i == 0 || i == RAND_ITEMS / 2);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (queued_reqs.size() != 0 || req_bus.valid || expected_updates.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d requests: %0d adds, %0d removes, %0d rejected, %0d filter flips",
                 req_transfers, n_add, n_remove, n_reject, n_filter_flips);
        $display("saturated adds %0d, removes at zero %0d, peak bucket count %0d",
                 n_saturated, n_remove_at_zero, peak_count);
        if (error_count == 0)
            $display("multicast_hash_filter_refcount_core_tb: PASS");
        else
            $display("multicast_hash_filter_refcount_core_tb: FAIL");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("timeout: %0d responses still due", expected_updates.size());
        $display("multicast_hash_filter_refcount_core_tb: FAIL");
        $finish;
    end

endmodule
